>>> rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, widths and token kind codes of the source text lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int TOKEN_LIMIT_DEF   = 4096;
    localparam int SOURCE_LIMIT_DEF  = 65536;
    localparam int KEYWORD_CHARS_DEF = 5;

    // Most results one input item can cause.
    localparam int MAX_RESULTS = 3;

    typedef enum logic [5:0] {
        K_SETW, K_SETB, K_PUB, K_FN, K_RET, K_IF, K_ELSE, K_WHILE, K_FOR, K_ARG,
        K_ID, K_INT, K_FLOAT, K_STR, K_CHAR, K_LP, K_RP, K_LBC, K_RBC, K_LBK,
        K_RBK, K_COM, K_SEMI, K_EQ, K_EQQ, K_NOT, K_NOTI, K_LT, K_LE, K_SL,
        K_GT, K_GE, K_SR, K_AND, K_BAND, K_BANDI, K_OR, K_BOR, K_BORI, K_XOR,
        K_XORI, K_BNOT, K_BNOTI, K_ADD, K_ADDI, K_INC, K_SUB, K_SUBI, K_DEC,
        K_MUL, K_MULI, K_DIV, K_DIVI, K_MOD, K_NEW, K_END
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE, E_BAD_CHAR, E_BAD_ESCAPE, E_TOO_MANY, E_END_IN_CHAR, E_TOO_LONG
    } t_err;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [31:0] literal_value;
        logic [2:0]  error_code;
        logic        last_of_run;
    } t_token;

    typedef struct packed {
        t_token [MAX_RESULTS-1:0] slot;
        logic [1:0]               count;
    } t_res_set;

endpackage

>>> rtl/stl_if.sv
// ----------------------------------------------------------------------------
// stl_byte_if / stl_token_if
// Valid/ready channels carrying source bytes in and tokens out.
// ----------------------------------------------------------------------------
interface stl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface stl_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [31:0] literal_value;
    logic [2:0]  error_code;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output literal_value, output error_code,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input start_offset,
                  input token_length, input literal_value, input error_code,
                  input last_of_run, output ready);
endinterface

>>> rtl/source_text_lexer_top.sv
// ----------------------------------------------------------------------------
// source_text_lexer_top
// Streaming lexer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// The i_text channel carries one source byte per request, or an end of text
// marker. The o_token channel carries one token per request: its kind, start
// offset, length, literal value, error code and a flag on the last token that
// a given input request caused.
// Each accepted byte is lexed in the same cycle against the lexer state and
// its tokens (none to three) are written into the result register, so the
// first token of a byte shows on o_token in the cycle after the byte is taken.
// A byte that gives at most one token leaves the result register ready for
// the next byte while the receiver takes every token, so plain text flows at
// one byte per clock. A byte that gives two or three tokens holds the input
// while the result register drains, until its last held token leaves.
// If the receiver stalls, tokens wait in the result register and i_text.ready
// drops once the held tokens cannot be replaced in the same cycle; nothing
// is lost. End of text flushes the pending token, emits the end token unless
// an error has ended the run, and returns the lexer to its reset state.
// Reset empties the result register and sets the lexer idle at offset zero.
// ----------------------------------------------------------------------------
module source_text_lexer_top #(
    parameter int TOKEN_LIMIT   = stl_pkg::TOKEN_LIMIT_DEF,
    parameter int SOURCE_LIMIT  = stl_pkg::SOURCE_LIMIT_DEF,
    parameter int KEYWORD_CHARS = stl_pkg::KEYWORD_CHARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    stl_byte_if.sink           i_text,
    stl_token_if.source        o_token
);

    stl_pkg::t_res_set res_set;
    stl_pkg::t_token   tok;
    logic              in_ready;
    logic              take;

    // A request is taken when the result register can accept its tokens.
    assign i_text.ready = in_ready;
    assign take         = i_text.valid && in_ready;

    stl_core #(
        .TOKEN_LIMIT   (TOKEN_LIMIT),
        .SOURCE_LIMIT  (SOURCE_LIMIT),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_text_byte   (i_text.text_byte),
        .i_end_of_text (i_text.end_of_text),
        .o_res         (res_set)
    );

    stl_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take),
        .i_set       (res_set),
        .i_out_ready (o_token.ready),
        .o_in_ready  (in_ready),
        .o_valid     (o_token.valid),
        .o_token     (tok)
    );

    // Output fields come straight from the head of the result register.
    assign o_token.token_kind    = tok.token_kind;
    assign o_token.start_offset  = tok.start_offset;
    assign o_token.token_length  = tok.token_length;
    assign o_token.literal_value = tok.literal_value;
    assign o_token.error_code    = tok.error_code;
    assign o_token.last_of_run   = tok.last_of_run;

endmodule

>>> rtl/stl_core.sv
// ----------------------------------------------------------------------------
// stl_core
// Lexer state and the one-pass next-state logic that turns one byte into up
// to three token results.
// ----------------------------------------------------------------------------
module stl_core #(
    parameter int TOKEN_LIMIT   = stl_pkg::TOKEN_LIMIT_DEF,
    parameter int SOURCE_LIMIT  = stl_pkg::SOURCE_LIMIT_DEF,
    parameter int KEYWORD_CHARS = stl_pkg::KEYWORD_CHARS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_text_byte,
    input  logic              i_end_of_text,
    output stl_pkg::t_res_set o_res
);

    localparam int P   = $clog2(SOURCE_LIMIT + 2);
    localparam int EW  = $clog2(TOKEN_LIMIT + 1);
    localparam int KIW = $clog2(KEYWORD_CHARS);

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_NL, M_COMMENT, M_SLASH, M_DEC, M_HEX, M_BIN,
        M_DOT, M_FLOAT, M_STRING, M_COPEN, M_CESC, M_CHEX, M_CBIN, M_CCLOSE,
        M_HELD
    } t_mode;

    typedef struct packed {
        logic        fail;
        logic [5:0]  kind;
        logic [P-1:0] start;
        logic [P-1:0] len;
        logic [31:0] val;
        logic [2:0]  code;
    } t_ev;

    t_mode        r_mode, n_mode;
    logic [P-1:0] r_pos, n_pos;
    logic [P-1:0] r_ts, n_ts;
    logic [P-1:0] r_rl, n_rl;
    logic [7:0]   r_kw [KEYWORD_CHARS];
    logic [7:0]   n_kw [KEYWORD_CHARS];
    logic [31:0]  r_va, n_va;
    logic [3:0]   r_edc, n_edc;
    logic [7:0]   r_hc, n_hc;
    logic [EW-1:0] r_ec, n_ec;
    logic         r_sink, n_sink;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hexd(input logic [7:0] c);
        return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hexd(input logic [7:0] c);
        logic [7:0] v;
        if (is_dig(c)) v = c - "0";
        else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
        else v = c - "A" + 8'd10;
        return v[3:0];
    endfunction

    // Kind of an operator; a pair byte of zero means the operator stands alone.
    function automatic logic [5:0] op_kind(input logic [7:0] h, input logic [7:0] p);
        logic [5:0] k;
        logic       pz;
        pz = (p == 8'd0);
        case (h)
            "+": k = p == "+" ? stl_pkg::K_INC : p == "=" ? stl_pkg::K_ADDI
                   : pz ? stl_pkg::K_ADD : 6'd0;
            "-": k = p == "-" ? stl_pkg::K_DEC : p == "=" ? stl_pkg::K_SUBI
                   : pz ? stl_pkg::K_SUB : 6'd0;
            "*": k = p == "=" ? stl_pkg::K_MULI : pz ? stl_pkg::K_MUL : 6'd0;
            "=": k = p == "=" ? stl_pkg::K_EQQ : pz ? stl_pkg::K_EQ : 6'd0;
            "!": k = p == "=" ? stl_pkg::K_NOTI : pz ? stl_pkg::K_NOT : 6'd0;
            "<": k = p == "<" ? stl_pkg::K_SL : p == "=" ? stl_pkg::K_LE
                   : pz ? stl_pkg::K_LT : 6'd0;
            ">": k = p == ">" ? stl_pkg::K_SR : p == "=" ? stl_pkg::K_GE
                   : pz ? stl_pkg::K_GT : 6'd0;
            "&": k = p == "&" ? stl_pkg::K_AND : p == "=" ? stl_pkg::K_BANDI
                   : pz ? stl_pkg::K_BAND : 6'd0;
            "|": k = p == "|" ? stl_pkg::K_OR : p == "=" ? stl_pkg::K_BORI
                   : pz ? stl_pkg::K_BOR : 6'd0;
            "^": k = p == "=" ? stl_pkg::K_XORI : pz ? stl_pkg::K_XOR : 6'd0;
            default: k = p == "=" ? stl_pkg::K_BNOTI : pz ? stl_pkg::K_BNOT : 6'd0;
        endcase
        return k;
    endfunction

    function automatic t_ev mk(input logic f, input logic [5:0] k, input logic [P-1:0] s,
                               input logic [P-1:0] l, input logic [31:0] v,
                               input logic [2:0] e);
        t_ev r;
        r.fail  = f;
        r.kind  = k;
        r.start = s;
        r.len   = l;
        r.val   = v;
        r.code  = e;
        return r;
    endfunction

    always_comb begin
        t_ev          ev [4];
        logic [1:0]   ne;
        logic         cont, do_fin, do_start;
        logic [7:0]   c, d;
        logic [5:0]   ok;
        logic [39:0]  w;
        logic [5:0]   ik;
        logic         sink_t;
        logic [EW-1:0] ec_t;
        logic [1:0]   k;
        logic [31:0]  len32;
        stl_pkg::t_token tk;

        n_mode = r_mode;
        n_pos  = r_pos;
        n_ts   = r_ts;
        n_rl   = r_rl;
        n_kw   = r_kw;
        n_va   = r_va;
        n_edc  = r_edc;
        n_hc   = r_hc;
        for (int i = 0; i < 4; i++) ev[i] = '0;
        ne       = 2'd0;
        cont     = 1'b0;
        do_fin   = 1'b0;
        do_start = 1'b0;
        c        = i_text_byte;
        d        = c - "0";
        ok       = op_kind(r_hc, c);

        if (i_end_of_text) begin
            do_fin = !r_sink;
        end else if (!r_sink) begin
            if (r_pos >= P'(SOURCE_LIMIT)) begin
                ev[ne] = mk(1'b1, '0, r_pos, '0, '0, stl_pkg::E_TOO_LONG);
                ne = ne + 2'd1;
            end else begin
                if (r_mode == M_IDLE) begin
                    do_start = 1'b1;
                end else begin
                    case (r_mode)
                        M_IDENT: begin
                            if (is_alpha(c) || is_dig(c)) begin
                                if (r_rl < P'(KEYWORD_CHARS)) n_kw[r_rl[KIW-1:0]] = c;
                                n_rl = r_rl + 1'b1;
                                cont = 1'b1;
                            end
                        end
                        M_NL: begin
                            if (c == "\n" || c == "\r") begin
                                n_ts = r_pos;
                                cont = 1'b1;
                            end
                        end
                        M_COMMENT: begin
                            if (c == "\n") n_mode = M_IDLE;
                            else cont = 1'b1;
                        end
                        M_SLASH: begin
                            if (c == "/") begin
                                n_mode = M_COMMENT;
                                cont   = 1'b1;
                            end else if (c == "=") begin
                                ev[ne] = mk(1'b0, stl_pkg::K_DIVI, r_ts, P'(2), '0, '0);
                                ne = ne + 2'd1;
                                n_mode = M_IDLE;
                                cont   = 1'b1;
                            end
                        end
                        M_DEC: begin
                            if (is_dig(c)) begin
                                n_va = (r_va << 3) + (r_va << 1) + 32'(d);
                                n_rl = r_rl + 1'b1;
                                cont = 1'b1;
                            end else if (r_rl == P'(1) && r_va == '0 && (c == "x" || c == "X")) begin
                                n_mode = M_HEX;
                                n_rl   = r_rl + 1'b1;
                                cont   = 1'b1;
                            end else if (r_rl == P'(1) && r_va == '0 && (c == "b" || c == "B")) begin
                                n_mode = M_BIN;
                                n_rl   = r_rl + 1'b1;
                                cont   = 1'b1;
                            end else if (c == ".") begin
                                n_mode = M_DOT;
                                cont   = 1'b1;
                            end
                        end
                        M_HEX: begin
                            if (is_hexd(c)) begin
                                n_va = {r_va[27:0], hexd(c)};
                                n_rl = r_rl + 1'b1;
                                cont = 1'b1;
                            end
                        end
                        M_BIN: begin
                            if (c == "0" || c == "1") begin
                                n_va = {r_va[30:0], c[0]};
                                n_rl = r_rl + 1'b1;
                                cont = 1'b1;
                            end
                        end
                        M_DOT: begin
                            if (is_dig(c)) begin
                                n_mode = M_FLOAT;
                                n_rl   = r_rl + P'(2);
                                cont   = 1'b1;
                            end
                        end
                        M_FLOAT: begin
                            if (is_dig(c)) begin
                                n_rl = r_rl + 1'b1;
                                cont = 1'b1;
                            end
                        end
                        M_STRING: begin
                            if (c == "\"") begin
                                ev[ne] = mk(1'b0, stl_pkg::K_STR, r_ts, r_rl, '0, '0);
                                ne = ne + 2'd1;
                                n_mode = M_IDLE;
                            end else begin
                                n_rl = r_rl + 1'b1;
                            end
                            cont = 1'b1;
                        end
                        M_COPEN: begin
                            if (c == "\\") begin
                                n_mode = M_CESC;
                            end else begin
                                n_va   = 32'(c);
                                n_mode = M_CCLOSE;
                            end
                            cont = 1'b1;
                        end
                        M_CESC: begin
                            n_mode = M_CCLOSE;
                            n_va   = '0;
                            n_edc  = '0;
                            case (c)
                                "n":  n_va = 32'h0a;
                                "t":  n_va = 32'h09;
                                "\\": n_va = 32'h5c;
                                "'":  n_va = 32'h27;
                                "0":  n_va = '0;
                                "x":  n_mode = M_CHEX;
                                "b":  n_mode = M_CBIN;
                                default: begin
                                    n_mode = M_IDLE;
                                    ev[ne] = mk(1'b1, '0, r_pos, '0, '0, stl_pkg::E_BAD_ESCAPE);
                                    ne = ne + 2'd1;
                                end
                            endcase
                            cont = 1'b1;
                        end
                        M_CHEX: begin
                            if (is_hexd(c)) begin
                                n_va  = {r_va[27:0], hexd(c)};
                                n_edc = r_edc + 4'd1;
                                if (n_edc >= 4'd2) n_mode = M_CCLOSE;
                            end else begin
                                ev[ne] = mk(1'b0, stl_pkg::K_CHAR, r_ts, r_pos - r_ts + 1'b1,
                                            r_va, '0);
                                ne = ne + 2'd1;
                                n_mode = M_IDLE;
                            end
                            cont = 1'b1;
                        end
                        M_CBIN: begin
                            if (c == "0" || c == "1") begin
                                n_va  = {r_va[30:0], c[0]};
                                n_edc = r_edc + 4'd1;
                                if (n_edc >= 4'd8) n_mode = M_CCLOSE;
                            end else begin
                                ev[ne] = mk(1'b0, stl_pkg::K_CHAR, r_ts, r_pos - r_ts + 1'b1,
                                            r_va, '0);
                                ne = ne + 2'd1;
                                n_mode = M_IDLE;
                            end
                            cont = 1'b1;
                        end
                        M_CCLOSE: begin
                            ev[ne] = mk(1'b0, stl_pkg::K_CHAR, r_ts, r_pos - r_ts + 1'b1,
                                        {24'd0, r_va[7:0]}, '0);
                            ne = ne + 2'd1;
                            n_mode = M_IDLE;
                            cont   = 1'b1;
                        end
                        M_HELD: begin
                            if (ok != 6'd0) begin
                                ev[ne] = mk(1'b0, ok, r_ts, P'(2), '0, '0);
                                ne = ne + 2'd1;
                                n_mode = M_IDLE;
                                cont   = 1'b1;
                            end
                        end
                        default: cont = 1'b0;
                    endcase
                    if (!cont) begin
                        do_fin   = 1'b1;
                        do_start = 1'b1;
                    end
                end
                n_pos = r_pos + 1'b1;
            end
        end

        // Close the token in progress.
        if (do_fin) begin
            w = {n_kw[0], n_kw[1], n_kw[2], n_kw[3], n_kw[4]};
            ik = stl_pkg::K_ID;
            if (n_rl <= P'(KEYWORD_CHARS)) begin
                if (n_rl == P'(3) && w[39:16] == "let") ik = stl_pkg::K_SETW;
                else if (n_rl == P'(3) && w[39:16] == "leb") ik = stl_pkg::K_SETB;
                else if (n_rl == P'(4) && w[39:8] == "setw") ik = stl_pkg::K_SETW;
                else if (n_rl == P'(4) && w[39:8] == "setb") ik = stl_pkg::K_SETB;
                else if (n_rl == P'(3) && w[39:16] == "pub") ik = stl_pkg::K_PUB;
                else if (n_rl == P'(2) && w[39:24] == "fn") ik = stl_pkg::K_FN;
                else if (n_rl == P'(3) && w[39:16] == "ret") ik = stl_pkg::K_RET;
                else if (n_rl == P'(2) && w[39:24] == "if") ik = stl_pkg::K_IF;
                else if (n_rl == P'(4) && w[39:8] == "else") ik = stl_pkg::K_ELSE;
                else if (n_rl == P'(5) && w == "while") ik = stl_pkg::K_WHILE;
                else if (n_rl == P'(3) && w[39:16] == "for") ik = stl_pkg::K_FOR;
                else if (n_rl == P'(3) && w[39:16] == "arg") ik = stl_pkg::K_ARG;
            end
            case (n_mode)
                M_IDENT: begin
                    ev[ne] = mk(1'b0, ik, n_ts, n_rl, '0, '0);
                    ne = ne + 2'd1;
                end
                M_NL: begin
                    ev[ne] = mk(1'b0, stl_pkg::K_NEW, n_ts, P'(1), '0, '0);
                    ne = ne + 2'd1;
                end
                M_SLASH: begin
                    ev[ne] = mk(1'b0, stl_pkg::K_DIV, n_ts, P'(1), '0, '0);
                    ne = ne + 2'd1;
                end
                M_DEC, M_HEX, M_BIN: begin
                    ev[ne] = mk(1'b0, stl_pkg::K_INT, n_ts, n_rl, n_va, '0);
                    ne = ne + 2'd1;
                end
                M_DOT: begin
                    ev[ne] = mk(1'b0, stl_pkg::K_INT, n_ts, n_rl, n_va, '0);
                    ne = ne + 2'd1;
                    ev[ne] = mk(1'b1, '0, n_ts + n_rl, '0, '0, stl_pkg::E_BAD_CHAR);
                    ne = ne + 2'd1;
                end
                M_FLOAT: begin
                    ev[ne] = mk(1'b0, stl_pkg::K_FLOAT, n_ts, n_rl, '0, '0);
                    ne = ne + 2'd1;
                end
                M_HELD: begin
                    ev[ne] = mk(1'b0, op_kind(n_hc, 8'd0), n_ts, P'(1), '0, '0);
                    ne = ne + 2'd1;
                end
                M_STRING: begin
                    if (i_end_of_text) begin
                        ev[ne] = mk(1'b0, stl_pkg::K_STR, n_ts, n_rl, '0, '0);
                        ne = ne + 2'd1;
                    end
                end
                M_COPEN, M_CESC, M_CHEX, M_CBIN, M_CCLOSE: begin
                    if (i_end_of_text) begin
                        ev[ne] = mk(1'b1, '0, r_pos, '0, '0, stl_pkg::E_END_IN_CHAR);
                        ne = ne + 2'd1;
                    end
                end
                default: ne = ne;
            endcase
            n_mode = M_IDLE;
        end

        // Begin a new token with this byte.
        if (do_start) begin
            n_mode = M_IDLE;
            n_ts   = r_pos;
            n_va   = '0;
            n_rl   = P'(1);
            if (c == " " || c == "\t") begin
                n_mode = M_IDLE;
            end else if (c == "\n" || c == "\r") begin
                n_mode = M_NL;
            end else if (c == "/") begin
                n_mode = M_SLASH;
            end else if (is_alpha(c)) begin
                n_kw[0] = c;
                n_mode  = M_IDENT;
            end else if (is_dig(c)) begin
                n_va   = 32'(d);
                n_mode = M_DEC;
            end else if (c == "\"") begin
                n_ts   = r_pos + 1'b1;
                n_rl   = '0;
                n_mode = M_STRING;
            end else if (c == "'") begin
                n_mode = M_COPEN;
            end else begin
                case (c)
                    "(": ev[ne] = mk(1'b0, stl_pkg::K_LP, r_pos, P'(1), '0, '0);
                    ")": ev[ne] = mk(1'b0, stl_pkg::K_RP, r_pos, P'(1), '0, '0);
                    "[": ev[ne] = mk(1'b0, stl_pkg::K_LBC, r_pos, P'(1), '0, '0);
                    "]": ev[ne] = mk(1'b0, stl_pkg::K_RBC, r_pos, P'(1), '0, '0);
                    "{": ev[ne] = mk(1'b0, stl_pkg::K_LBK, r_pos, P'(1), '0, '0);
                    "}": ev[ne] = mk(1'b0, stl_pkg::K_RBK, r_pos, P'(1), '0, '0);
                    ",": ev[ne] = mk(1'b0, stl_pkg::K_COM, r_pos, P'(1), '0, '0);
                    ";": ev[ne] = mk(1'b0, stl_pkg::K_SEMI, r_pos, P'(1), '0, '0);
                    "%": ev[ne] = mk(1'b0, stl_pkg::K_MOD, r_pos, P'(1), '0, '0);
                    "+", "-", "*", "=", "!", "<", ">", "&", "|", "^", "~": begin
                        n_hc   = c;
                        n_mode = M_HELD;
                    end
                    default: ev[ne] = mk(1'b1, '0, r_pos, '0, '0, stl_pkg::E_BAD_CHAR);
                endcase
                if (n_mode != M_HELD) ne = ne + 2'd1;
            end
        end

        if (i_end_of_text && !r_sink) begin
            ev[ne] = mk(1'b0, stl_pkg::K_END, r_pos, '0, '0, '0);
            ne = ne + 2'd1;
        end

        // Pass the requests through the token limit and the error sink.
        sink_t = r_sink;
        ec_t   = r_ec;
        k      = 2'd0;
        o_res  = '0;
        for (int i = 0; i < stl_pkg::MAX_RESULTS; i++) begin
            if (2'(i) < ne && !sink_t) begin
                if (!ev[i].fail && ec_t >= EW'(TOKEN_LIMIT)) begin
                    ev[i].fail = 1'b1;
                    ev[i].code = stl_pkg::E_TOO_MANY;
                end
                len32 = 32'(ev[i].len);
                tk.token_kind    = ev[i].fail ? stl_pkg::K_END : ev[i].kind;
                tk.start_offset  = 16'(ev[i].start);
                tk.token_length  = ev[i].fail ? 16'd0
                                 : (len32 > 32'hffff ? 16'hffff : len32[15:0]);
                tk.literal_value = ev[i].fail ? 32'd0 : ev[i].val;
                tk.error_code    = ev[i].fail ? ev[i].code : stl_pkg::E_NONE;
                tk.last_of_run   = 1'b0;
                o_res.slot[k]    = tk;
                k = k + 2'd1;
                if (ev[i].fail) sink_t = 1'b1;
                else ec_t = ec_t + 1'b1;
            end
        end
        o_res.count = k;
        if (k != 2'd0) o_res.slot[k - 2'd1].last_of_run = 1'b1;
        n_sink = sink_t;
        n_ec   = ec_t;

        if (i_end_of_text) begin
            n_mode = M_IDLE;
            n_pos  = '0;
            n_ts   = '0;
            n_rl   = '0;
            n_va   = '0;
            n_edc  = '0;
            n_hc   = '0;
            n_ec   = '0;
            n_sink = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pos  <= '0;
            r_ts   <= '0;
            r_rl   <= '0;
            r_va   <= '0;
            r_edc  <= '0;
            r_hc   <= '0;
            r_ec   <= '0;
            r_sink <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_ts   <= n_ts;
            r_rl   <= n_rl;
            r_va   <= n_va;
            r_edc  <= n_edc;
            r_hc   <= n_hc;
            r_ec   <= n_ec;
            r_sink <= n_sink;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_kw <= n_kw;
        end
    end

endmodule

>>> rtl/stl_outq.sv
// ----------------------------------------------------------------------------
// stl_outq
// Result register: holds the up to three tokens of one byte and hands them
// out one per handshake.
// ----------------------------------------------------------------------------
module stl_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  stl_pkg::t_res_set i_set,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_valid,
    output stl_pkg::t_token   o_token
);

    stl_pkg::t_token [stl_pkg::MAX_RESULTS-1:0] r_slot;
    logic [1:0] r_cnt;
    logic       fire;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_token    = r_slot[0];
    assign fire       = o_valid && i_out_ready;
    // A new set may land when the register is empty or once the last held token leaves in this cycle.
    assign o_in_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_set.count;
        end else if (fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_set.slot;
        end else if (fire) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

endmodule

>>> rtl/stl_check.sv
// ----------------------------------------------------------------------------
// stl_check
// Port-level checks on the token channel of the lexer.
// ----------------------------------------------------------------------------
module stl_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [5:0]  i_kind,
    input logic [15:0] i_len,
    input logic [31:0] i_val,
    input logic [2:0]  i_err
);

    // An error result is an end token with no length and no value.
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_err != stl_pkg::E_NONE |->
            i_kind == stl_pkg::K_END && i_len == 16'd0 && i_val == 32'd0)
        else $error("error result not shaped as an end token");

    // Only end tokens may carry an error code.
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != stl_pkg::K_END |-> i_err == stl_pkg::E_NONE)
        else $error("error code on a regular token");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_valid)
        else $error("token valid right after reset");

    // A stalled token holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_len)
            && $stable(i_val) && $stable(i_err))
        else $error("stalled token changed");

endmodule

bind source_text_lexer_top stl_check u_stl_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_token.valid),
    .i_ready (o_token.ready),
    .i_kind  (o_token.token_kind),
    .i_len   (o_token.token_length),
    .i_val   (o_token.literal_value),
    .i_err   (o_token.error_code)
);

>>> tb/sv/tb_source_text_lexer_top.sv
// ----------------------------------------------------------------------------
// tb_source_text_lexer_top
// Self-checking testbench of the streaming source text lexer.
// ----------------------------------------------------------------------------
// Source texts are queued by an initial block and fed byte by byte by a
// clocked driver. Every accepted request runs through a behavioral lexer
// kept in this module, and the tokens it predicts are compared field by
// field with the tokens seen on the output channel.
// ----------------------------------------------------------------------------
module tb_source_text_lexer_top;
    import stl_pkg::*;

    localparam int TOKEN_LIMIT  = 4096;
    localparam int SOURCE_LIMIT = 65536;
    localparam int KW_CHARS     = 5;
    localparam int CYCLE_LIMIT  = 900000;
    localparam int NO_PAIR      = -1;

    typedef enum int {
        LM_IDLE, LM_IDENT, LM_NL, LM_COMMENT, LM_SLASH, LM_DEC, LM_HEX, LM_BIN,
        LM_DOT, LM_FLOAT, LM_STRING, LM_COPEN, LM_CESC, LM_CHEX, LM_CBIN,
        LM_CCLOSE, LM_HELD
    } t_lex_mode;

    typedef enum int { Q_BYTE, Q_DRAIN, Q_PHASE } t_req_kind;

    typedef struct {
        t_req_kind  what;
        logic [7:0] text_byte;
        logic       eot;
        int         send_idle;
        int         recv_idle;
    } t_req;

    logic i_clk;
    logic i_rst_n;
    stl_byte_if  text_ch ();
    stl_token_if token_ch ();

    source_text_lexer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_ch.sink),
        .o_token (token_ch.source)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    t_req   req_queue[$];
    t_token token_expect[$];
    int     send_idle_pct, recv_idle_pct;
    int     errors, tokens_seen, cycles;
    int     hold_left;
    bit     hold_done;
    logic   byte_taken;

    // ------------------------------------------------------------------
    // Behavioral lexer state.
    // ------------------------------------------------------------------
    t_lex_mode   lx_mode;
    int unsigned lx_pos, lx_start, lx_len, lx_acc, lx_digits, lx_count;
    logic [7:0]  lx_held;
    logic [7:0]  lx_kw[KW_CHARS];
    bit          lx_sink;
    t_token      step_tokens[$];

    string kw_text[12] = '{"let", "leb", "setw", "setb", "pub", "fn", "ret", "if",
                           "else", "while", "for", "arg"};
    t_kind kw_kind[12] = '{K_SETW, K_SETB, K_SETW, K_SETB, K_PUB, K_FN, K_RET,
                           K_IF, K_ELSE, K_WHILE, K_FOR, K_ARG};

    function automatic void lex_reset();
        lx_mode = LM_IDLE;
        lx_pos = 0; lx_start = 0; lx_len = 0; lx_acc = 0;
        lx_digits = 0; lx_count = 0; lx_held = 8'h00; lx_sink = 1'b0;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic int unsigned hex_val(logic [7:0] c);
        if (is_digit(c)) return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return c - "A" + 10;
    endfunction

    function automatic void put_token(t_kind kind, int unsigned start, int unsigned len,
                                      int unsigned val, t_err err);
        t_token t;
        if (step_tokens.size() >= MAX_RESULTS) return;
        t.token_kind    = kind;
        t.start_offset  = start[15:0];
        t.token_length  = (len > 65535) ? 16'hFFFF : len[15:0];
        t.literal_value = val;
        t.error_code    = err;
        t.last_of_run   = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void raise_error(int unsigned pos, t_err err);
        if (lx_sink) return;
        put_token(K_END, pos, 0, 0, err);
        lx_sink = 1'b1;
    endfunction

    function automatic void emit_token(t_kind kind, int unsigned start, int unsigned len,
                                       int unsigned val);
        if (lx_sink) return;
        if (lx_count >= TOKEN_LIMIT) begin
            raise_error(start, E_TOO_MANY);
            return;
        end
        put_token(kind, start, len, val, E_NONE);
        lx_count++;
    endfunction

    function automatic t_kind word_kind();
        bit same;
        if (lx_len > KW_CHARS) return K_ID;
        for (int j = 0; j < 12; j++) begin
            if (kw_text[j].len() == lx_len) begin
                same = 1'b1;
                for (int i = 0; i < lx_len; i++)
                    if (lx_kw[i] != kw_text[j][i]) same = 1'b0;
                if (same) return kw_kind[j];
            end
        end
        return K_ID;
    endfunction

    // Kind of an operator: the held character alone when alone is set, else
    // followed by nxt; NO_PAIR when that pair is not an operator.
    function automatic int oper_kind(logic [7:0] h, logic [7:0] nxt, bit alone);
        case (h)
            "+": return alone ? K_ADD : nxt == "+" ? K_INC : nxt == "=" ? K_ADDI : NO_PAIR;
            "-": return alone ? K_SUB : nxt == "-" ? K_DEC : nxt == "=" ? K_SUBI : NO_PAIR;
            "*": return alone ? K_MUL : nxt == "=" ? K_MULI : NO_PAIR;
            "=": return alone ? K_EQ : nxt == "=" ? K_EQQ : NO_PAIR;
            "!": return alone ? K_NOT : nxt == "=" ? K_NOTI : NO_PAIR;
            "<": return alone ? K_LT : nxt == "<" ? K_SL : nxt == "=" ? K_LE : NO_PAIR;
            ">": return alone ? K_GT : nxt == ">" ? K_SR : nxt == "=" ? K_GE : NO_PAIR;
            "&": return alone ? K_BAND : nxt == "&" ? K_AND : nxt == "=" ? K_BANDI : NO_PAIR;
            "|": return alone ? K_BOR : nxt == "|" ? K_OR : nxt == "=" ? K_BORI : NO_PAIR;
            "^": return alone ? K_XOR : nxt == "=" ? K_XORI : NO_PAIR;
            default: return alone ? K_BNOT : nxt == "=" ? K_BNOTI : NO_PAIR;
        endcase
    endfunction

    function automatic void begin_token(logic [7:0] c, int unsigned pos);
        lx_mode = LM_IDLE; lx_start = pos; lx_acc = 0; lx_len = 1;
        if (c == " " || c == "\t") return;
        if (c == "\n" || c == 8'h0D) begin lx_mode = LM_NL; return; end
        if (c == "/") begin lx_mode = LM_SLASH; return; end
        if (is_alpha(c)) begin lx_kw[0] = c; lx_mode = LM_IDENT; return; end
        if (is_digit(c)) begin lx_acc = c - "0"; lx_mode = LM_DEC; return; end
        if (c == "\"") begin
            lx_start = pos + 1; lx_len = 0; lx_mode = LM_STRING;
            return;
        end
        if (c == "'") begin lx_mode = LM_COPEN; return; end
        case (c)
            "(": emit_token(K_LP, pos, 1, 0);
            ")": emit_token(K_RP, pos, 1, 0);
            "[": emit_token(K_LBC, pos, 1, 0);
            "]": emit_token(K_RBC, pos, 1, 0);
            "{": emit_token(K_LBK, pos, 1, 0);
            "}": emit_token(K_RBK, pos, 1, 0);
            ",": emit_token(K_COM, pos, 1, 0);
            ";": emit_token(K_SEMI, pos, 1, 0);
            "%": emit_token(K_MOD, pos, 1, 0);
            "+", "-", "*", "=", "!", "<", ">", "&", "|", "^", "~": begin
                lx_held = c; lx_mode = LM_HELD;
            end
            default: raise_error(pos, E_BAD_CHAR);
        endcase
    endfunction

    function automatic void flush_token(bit at_end);
        t_lex_mode m = lx_mode;
        lx_mode = LM_IDLE;
        case (m)
            LM_IDENT: emit_token(word_kind(), lx_start, lx_len, 0);
            LM_NL: emit_token(K_NEW, lx_start, 1, 0);
            LM_SLASH: emit_token(K_DIV, lx_start, 1, 0);
            LM_DEC, LM_HEX, LM_BIN: emit_token(K_INT, lx_start, lx_len, lx_acc);
            LM_DOT: begin
                emit_token(K_INT, lx_start, lx_len, lx_acc);
                raise_error(lx_start + lx_len, E_BAD_CHAR);
            end
            LM_FLOAT: emit_token(K_FLOAT, lx_start, lx_len, 0);
            LM_HELD: emit_token(t_kind'(oper_kind(lx_held, 8'h00, 1'b1)), lx_start, 1, 0);
            LM_STRING: if (at_end) emit_token(K_STR, lx_start, lx_len, 0);
            LM_COPEN, LM_CESC, LM_CHEX, LM_CBIN, LM_CCLOSE:
                if (at_end) raise_error(lx_pos, E_END_IN_CHAR);
            default: ;
        endcase
    endfunction

    // Returns 1 when the byte extends or closes the token in progress.
    function automatic bit extend_token(logic [7:0] c, int unsigned pos);
        int op;
        case (lx_mode)
            LM_IDENT: begin
                if (!(is_alpha(c) || is_digit(c))) return 1'b0;
                if (lx_len < KW_CHARS) lx_kw[lx_len] = c;
                lx_len++;
                return 1'b1;
            end
            LM_NL: begin
                if (c != "\n" && c != 8'h0D) return 1'b0;
                lx_start = pos;
                return 1'b1;
            end
            LM_COMMENT: begin
                if (c == "\n") begin lx_mode = LM_IDLE; return 1'b0; end
                return 1'b1;
            end
            LM_SLASH: begin
                if (c == "/") begin lx_mode = LM_COMMENT; return 1'b1; end
                if (c == "=") begin
                    emit_token(K_DIVI, lx_start, 2, 0);
                    lx_mode = LM_IDLE;
                    return 1'b1;
                end
                return 1'b0;
            end
            LM_DEC: begin
                if (is_digit(c)) begin
                    lx_acc = lx_acc * 10 + (c - "0"); lx_len++;
                    return 1'b1;
                end
                if (lx_len == 1 && lx_acc == 0 && (c == "x" || c == "X")) begin
                    lx_mode = LM_HEX; lx_len++;
                    return 1'b1;
                end
                if (lx_len == 1 && lx_acc == 0 && (c == "b" || c == "B")) begin
                    lx_mode = LM_BIN; lx_len++;
                    return 1'b1;
                end
                if (c == ".") begin lx_mode = LM_DOT; return 1'b1; end
                return 1'b0;
            end
            LM_HEX: begin
                if (!is_hex(c)) return 1'b0;
                lx_acc = lx_acc * 16 + hex_val(c); lx_len++;
                return 1'b1;
            end
            LM_BIN: begin
                if (c != "0" && c != "1") return 1'b0;
                lx_acc = lx_acc * 2 + (c - "0"); lx_len++;
                return 1'b1;
            end
            LM_DOT: begin
                if (!is_digit(c)) return 1'b0;
                lx_mode = LM_FLOAT; lx_len += 2;
                return 1'b1;
            end
            LM_FLOAT: begin
                if (!is_digit(c)) return 1'b0;
                lx_len++;
                return 1'b1;
            end
            LM_STRING: begin
                if (c == "\"") begin
                    emit_token(K_STR, lx_start, lx_len, 0);
                    lx_mode = LM_IDLE;
                end else begin
                    lx_len++;
                end
                return 1'b1;
            end
            LM_COPEN: begin
                if (c == "\\") begin
                    lx_mode = LM_CESC;
                end else begin
                    lx_acc = c; lx_mode = LM_CCLOSE;
                end
                return 1'b1;
            end
            LM_CESC: begin
                lx_mode = LM_CCLOSE; lx_acc = 0; lx_digits = 0;
                case (c)
                    "n": lx_acc = 10;
                    "t": lx_acc = 9;
                    "\\": lx_acc = 92;
                    "'": lx_acc = 39;
                    "0": ;
                    "x": lx_mode = LM_CHEX;
                    "b": lx_mode = LM_CBIN;
                    default: begin
                        lx_mode = LM_IDLE;
                        raise_error(pos, E_BAD_ESCAPE);
                    end
                endcase
                return 1'b1;
            end
            LM_CHEX: begin
                if (is_hex(c)) begin
                    lx_acc = lx_acc * 16 + hex_val(c);
                    if (++lx_digits >= 2) lx_mode = LM_CCLOSE;
                    return 1'b1;
                end
                emit_token(K_CHAR, lx_start, pos - lx_start + 1, lx_acc);
                lx_mode = LM_IDLE;
                return 1'b1;
            end
            LM_CBIN: begin
                if (c == "0" || c == "1") begin
                    lx_acc = lx_acc * 2 + (c - "0");
                    if (++lx_digits >= 8) lx_mode = LM_CCLOSE;
                    return 1'b1;
                end
                emit_token(K_CHAR, lx_start, pos - lx_start + 1, lx_acc);
                lx_mode = LM_IDLE;
                return 1'b1;
            end
            LM_CCLOSE: begin
                emit_token(K_CHAR, lx_start, pos - lx_start + 1, lx_acc & 32'hFF);
                lx_mode = LM_IDLE;
                return 1'b1;
            end
            LM_HELD: begin
                op = oper_kind(lx_held, c, 1'b0);
                if (op == NO_PAIR) return 1'b0;
                emit_token(t_kind'(op), lx_start, 2, 0);
                lx_mode = LM_IDLE;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Runs one accepted request through the lexer and queues its tokens.
    function automatic void lex_request(logic [7:0] c, logic eot);
        int unsigned pos;
        step_tokens.delete();
        if (eot) begin
            if (!lx_sink) begin
                flush_token(1'b1);
                emit_token(K_END, lx_pos, 0, 0);
            end
            lex_reset();
        end else if (!lx_sink) begin
            if (lx_pos >= SOURCE_LIMIT) begin
                raise_error(lx_pos, E_TOO_LONG);
            end else begin
                pos = lx_pos;
                if (lx_mode == LM_IDLE) begin
                    begin_token(c, pos);
                end else if (!extend_token(c, pos)) begin
                    flush_token(1'b0);
                    if (!lx_sink) begin_token(c, pos);
                end
                lx_pos++;
            end
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
        foreach (step_tokens[i]) token_expect.push_back(step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b);
        t_req r;
        r.what = Q_BYTE; r.text_byte = b; r.eot = 1'b0;
        req_queue.push_back(r);
    endfunction

    // End of text carries a random byte, which the block must ignore.
    function automatic void add_end();
        t_req r;
        r.what = Q_BYTE; r.text_byte = 8'($urandom); r.eot = 1'b1;
        req_queue.push_back(r);
    endfunction

    function automatic void add_text(string s, bit close);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
        if (close) add_end();
    endfunction

    function automatic void add_marker(t_req_kind what, int s_idle, int r_idle);
        t_req r;
        r.what = what; r.text_byte = 8'h00; r.eot = 1'b0;
        r.send_idle = s_idle; r.recv_idle = r_idle;
        req_queue.push_back(r);
    endfunction

    function automatic string random_word(int n);
        string s = "";
        string pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        for (int i = 0; i < n; i++)
            s = {s, string'(pool[(i == 0) ? $urandom_range(0, 52) : $urandom_range(0, 62)])};
        return s;
    endfunction

    function automatic string random_digits(int n, string pool);
        string s = "";
        for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(0, pool.len() - 1)])};
        return s;
    endfunction

    // One well-formed token with random content, mostly.
    function automatic string random_lexeme();
        string ops[] = '{"+", "++", "+=", "-", "--", "-=", "*", "*=", "=", "==", "!", "!=",
                         "<", "<=", "<<", ">", ">=", ">>", "&", "&&", "&=", "|", "||", "|=",
                         "^", "^=", "~", "~=", "/", "/=", "(", ")", "[", "]", "{", "}",
                         ",", ";", "%"};
        string esc[] = '{"n", "t", "\\", "'", "0"};
        case ($urandom_range(0, 11))
            0: return kw_text[$urandom_range(0, 11)];
            1: return random_word($urandom_range(1, 9));
            2: return random_digits($urandom_range(1, 12), "0123456789");
            3: return {"0x", random_digits($urandom_range(0, 9), "0123456789abcdefABCDEF")};
            4: return {"0b", random_digits($urandom_range(0, 34), "01")};
            5: return {random_digits($urandom_range(1, 4), "0123456789"), ".",
                       random_digits($urandom_range(1, 4), "0123456789")};
            6: return {"\"", random_word($urandom_range(0, 6)), "\""};
            7: case ($urandom_range(0, 3))
                   0: return {"'", string'(8'($urandom_range(32, 126))), "'"};
                   1: return {"'\\", esc[$urandom_range(0, 4)], "'"};
                   2: return {"'\\x", random_digits($urandom_range(0, 2), "0123456789abcdefAF"),
                              "'"};
                   default: return {"'\\b", random_digits($urandom_range(0, 8), "01"), "'"};
               endcase
            8: return ops[$urandom_range(0, ops.size() - 1)];
            9: return {"// ", random_word(4), "\n"};
            10: return random_digits($urandom_range(1, 3), "\n\r");
            default: return random_digits($urandom_range(1, 2), " \t");
        endcase
    endfunction

    function automatic void add_random_text();
        int n = $urandom_range(2, 10);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) add_byte(8'($urandom));
            else add_text(random_lexeme(), 1'b0);
            if ($urandom_range(0, 2) == 0) add_byte(" ");
        end
        add_end();
    endfunction

    function automatic void add_random_phase(int texts);
        for (int i = 0; i < texts; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                for (int j = $urandom_range(1, 8); j > 0; j--) add_byte(8'($urandom));
                add_end();
            end else begin
                add_random_text();
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued requests at the falling edge. Markers in the
    // queue change idling rates or hold the sender until all tokens are in.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        byte_taken <= text_ch.valid && text_ch.ready;
        if (i_rst_n && text_ch.valid && text_ch.ready) begin
            lex_request(text_ch.text_byte, text_ch.end_of_text);
            void'(req_queue.pop_front());
        end
    end

    always @(negedge i_clk) begin
        logic offer;
        offer = 1'b0;
        if (!i_rst_n) begin
            text_ch.valid <= 1'b0;
        end else if (text_ch.valid && !byte_taken) begin
            // The current request has not been taken yet; keep it up.
        end else begin
            while (req_queue.size() > 0 && req_queue[0].what != Q_BYTE &&
                   (req_queue[0].what == Q_PHASE || token_expect.size() == 0)) begin
                if (req_queue[0].what == Q_PHASE) begin
                    send_idle_pct = req_queue[0].send_idle;
                    recv_idle_pct = req_queue[0].recv_idle;
                end
                void'(req_queue.pop_front());
            end
            if (req_queue.size() > 0 && req_queue[0].what == Q_BYTE &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                offer = 1'b1;
                text_ch.text_byte   <= req_queue[0].text_byte;
                text_ch.end_of_text <= req_queue[0].eot;
            end
            text_ch.valid <= offer;
        end
    end

    // Receiver: random stalls, plus one long hold-off so that the result
    // register fills and the input channel has to back off.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            token_ch.ready <= 1'b0;
        end else if (!hold_done && tokens_seen >= 30) begin
            hold_done <= 1'b1;
            hold_left <= 120;
            token_ch.ready <= 1'b0;
        end else begin
            token_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each token taken from the block with the oldest
    // predicted token.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && token_ch.valid && token_ch.ready) begin
            tokens_seen <= tokens_seen + 1;
            if (token_expect.size() == 0) begin
                $error("unexpected token kind %0d at offset %0d",
                       token_ch.token_kind, token_ch.start_offset);
                errors++;
            end else begin
                want = token_expect.pop_front();
                if (token_ch.token_kind !== want.token_kind) begin
                    $error("token_kind: expected %0d, got %0d",
                           want.token_kind, token_ch.token_kind);
                    errors++;
                end
                if (token_ch.start_offset !== want.start_offset) begin
                    $error("start_offset: expected %0d, got %0d",
                           want.start_offset, token_ch.start_offset);
                    errors++;
                end
                if (token_ch.token_length !== want.token_length) begin
                    $error("token_length: expected %0d, got %0d",
                           want.token_length, token_ch.token_length);
                    errors++;
                end
                if (token_ch.literal_value !== want.literal_value) begin
                    $error("literal_value: expected %0d, got %0d",
                           want.literal_value, token_ch.literal_value);
                    errors++;
                end
                if (token_ch.error_code !== want.error_code) begin
                    $error("error_code: expected %0d, got %0d",
                           want.error_code, token_ch.error_code);
                    errors++;
                end
                if (token_ch.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d",
                           want.last_of_run, token_ch.last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        string long_text;
        errors = 0; tokens_seen = 0; cycles = 0;
        hold_left = 0; hold_done = 1'b0;
        send_idle_pct = 22; recv_idle_pct = 55;
        byte_taken = 1'b0;
        text_ch.valid = 1'b0; text_ch.text_byte = 8'h00; text_ch.end_of_text = 1'b0;
        token_ch.ready = 1'b0;
        lex_reset();
        i_rst_n = 1'b0;

        add_marker(Q_PHASE, 22, 55);
        // Keywords, identifiers and a collapsed newline run.
        add_text("let leb setw setb pub fn ret if else while for arg foo_B9 abcdef\n\r\n",
                 1'b1);
        // Every one- and two-character operator and the punctuation.
        add_text("+ ++ += - -- -= * *= = == ! != < <= << > >= >> & && &= | || |=", 1'b0);
        add_text(" ^ ^= ~ ~= / /= ( ) [ ] { } , ; % ~", 1'b1);
        // Number forms: wrapping decimal, prefixes, bare prefixes, float, and
        // a number followed by a dot that is not followed by a digit.
        add_text("4294967297 0x1fA 0XFF 0b101 0B 0x 12.50", 1'b1);
        add_text("7.a", 1'b1);
        // Strings and char literals with every escape, then the comment.
        add_text("\"abc\" \"\" 'a' '\\n' '\\t' '\\\\' '\\'' '\\0' '\\x4' '\\x41' ", 1'b0);
        add_text("'\\b1' '\\b11111111' 'zq // note\n/", 1'b1);
        add_byte(8'hFF); add_byte(8'h00); add_end();                // bad char
        add_text("'\\q' 1 2", 1'b1);                                // bad escape
        add_text("x '\\x4", 1'b1);                                  // end inside char
        add_text("\"open", 1'b1);                                   // unterminated string
        add_text("ab;", 1'b0); add_end();
        add_random_phase(12);
        add_marker(Q_DRAIN, 0, 0);

        add_marker(Q_PHASE, 55, 22);
        add_random_phase(12);
        add_marker(Q_DRAIN, 0, 0);

        add_marker(Q_PHASE, 0, 0);
        add_random_phase(12);
        // Token limit: one token past the limit is refused.
        for (int i = 0; i <= TOKEN_LIMIT; i++) add_byte("(");
        add_end();
        // Source limit: the byte at the limit position is refused.
        for (int i = 0; i < SOURCE_LIMIT; i++) add_byte(" ");
        add_text("a b", 1'b1);
        add_random_phase(4);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (req_queue.size() == 0 && token_expect.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && token_expect.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/stl_pkg.sv
rtl/stl_if.sv
rtl/stl_core.sv
rtl/stl_outq.sv
rtl/source_text_lexer_top.sv
rtl/stl_check.sv
tb/sv/tb_source_text_lexer_top.sv
